// File: hdl/bsa_pkg.sv
// shared types, codes and defaults for the banker's safe allocator
package bsa_pkg;

    // default sizes handed to the top level
    localparam int CLIENTS_DEF    = 4;
    localparam int KINDS_DEF      = 4;
    localparam int COUNT_BITS_DEF = 4;

    // fixed field widths of the ports
    localparam int CFG_BITS     = 63;
    localparam int ACTION_BITS  = 3;
    localparam int CLIENT_BITS  = 2;
    localparam int AMOUNT_BITS  = 4;
    localparam int AMOUNT_PORTS = 4;
    localparam int STATUS_BITS  = 2;
    localparam int REFUSAL_BITS = 16;

    // claim register after reset: client c claims one unit of each kind k with k%2 == c%2
    localparam logic [CFG_BITS-1:0] CLAIM_RESET = 63'h1010010110100101;

    // action codes
    localparam logic [ACTION_BITS-1:0] ACT_REQUEST      = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_GRANT        = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_RELEASE      = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_LOAD_FREE    = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_QUERY_SAFE   = 3'd4;
    localparam logic [ACTION_BITS-1:0] ACT_QUERY_FINISH = 3'd5;

    // result status codes
    localparam logic [STATUS_BITS-1:0] STAT_DONE       = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_OVER_CLAIM = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_SHORT_FREE = 2'd2;
    localparam logic [STATUS_BITS-1:0] STAT_UNSAFE     = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WINIT,
        ST_WALK,
        ST_UNDO,
        ST_RESP
    } bsa_state_t;

endpackage

// File: hdl/bankers_safe_allocator_core.sv
// banker's deadlock-avoidance allocator with an iterative safety walk
//
//  channel   signals                                  direction  carries
//  cfg       cfg_valid / cfg_ready / cfg_data         in         max claim fields
//  s_        s_valid / s_ready / s_action .. amount   in         one request
//  m_        m_valid / m_ready / m_ok .. m_refusals   out        one result per request
//
//  grant, release, load, can-finish, no-op and failed checks: idle, execute, response
//  walked request or safety query: idle, execute, walk init, walk, response, plus undo for a rollback;
//  the walk checks one client row per cycle against the work vector, up to CLIENTS sweeps
//  synchronous active-low reset: free counts to one, holdings and refusals to zero, safe flag set
//  s_ready is high only in idle; a new request is taken while an old result still waits on m_ready
//  a result waiting on m_ready holds the sequencer in its response state
module bankers_safe_allocator_core #(
    parameter int CLIENTS    = bsa_pkg::CLIENTS_DEF,
    parameter int KINDS      = bsa_pkg::KINDS_DEF,
    parameter int COUNT_BITS = bsa_pkg::COUNT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // claim register write
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bsa_pkg::CFG_BITS-1:0]       cfg_data,
    // request channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [bsa_pkg::ACTION_BITS-1:0]    s_action,
    input  logic [bsa_pkg::CLIENT_BITS-1:0]    s_client,
    input  logic [bsa_pkg::AMOUNT_BITS-1:0]    s_amount_0,
    input  logic [bsa_pkg::AMOUNT_BITS-1:0]    s_amount_1,
    input  logic [bsa_pkg::AMOUNT_BITS-1:0]    s_amount_2,
    input  logic [bsa_pkg::AMOUNT_BITS-1:0]    s_amount_3,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_ok,
    output logic [bsa_pkg::STATUS_BITS-1:0]    m_status,
    output logic                               m_safe_now,
    output logic [bsa_pkg::REFUSAL_BITS-1:0]   m_refusals
);
    import bsa_pkg::*;

    localparam int CLI_BITS  = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int ROWS      = 1 << CLI_BITS;
    // work vector holds free plus every client's holdings
    localparam int WORK_BITS = COUNT_BITS + $clog2(CLIENTS + 1);
    localparam int EXT_BITS  = CFG_BITS + ROWS * KINDS * COUNT_BITS;
    localparam logic [COUNT_BITS-1:0]   COUNT_MAX  = '1;
    localparam logic [CLI_BITS-1:0]     LAST_IDX   = CLI_BITS'(CLIENTS - 1);
    localparam logic [CLIENT_BITS:0]    CLIENTS_W  = (CLIENT_BITS + 1)'(CLIENTS);

    // state
    bsa_state_t state_reg, state_next;
    logic [CFG_BITS-1:0]                            claims_reg;
    logic [KINDS-1:0][COUNT_BITS-1:0]               free_reg;
    logic [ROWS-1:0][KINDS-1:0][COUNT_BITS-1:0]     held_reg;
    logic [REFUSAL_BITS-1:0]                        refusal_reg;
    logic                                           safe_reg;

    // latched request
    logic [ACTION_BITS-1:0]                         action_reg;
    logic [CLIENT_BITS-1:0]                         client_reg;
    logic [AMOUNT_PORTS-1:0][AMOUNT_BITS-1:0]       amount_reg;

    // pending result
    logic                                           ok_reg;
    logic [STATUS_BITS-1:0]                         status_reg;

    // walk state
    logic [KINDS-1:0][WORK_BITS-1:0]                work_reg;
    logic [CLIENTS-1:0]                             done_reg;
    logic [CLI_BITS-1:0]                            walk_idx_reg;
    logic                                           progress_reg;

    // output register
    logic                                           m_valid_reg;
    logic                                           m_ok_reg;
    logic [STATUS_BITS-1:0]                         m_status_reg;
    logic                                           m_safe_reg;
    logic [REFUSAL_BITS-1:0]                        m_refusal_reg;

    // datapath signals
    logic [EXT_BITS-1:0]                            claims_ext;
    logic [ROWS-1:0][KINDS-1:0][COUNT_BITS-1:0]     claim_arr;
    logic [CLI_BITS-1:0]                            row_sel;
    logic [KINDS-1:0][COUNT_BITS-1:0]               held_row;
    logic [KINDS-1:0][COUNT_BITS-1:0]               need_row;
    logic [KINDS-1:0][WORK_BITS-1:0]                amt_w;
    logic [KINDS-1:0][COUNT_BITS-1:0]               amt_c;
    logic                                           client_ok;
    logic                                           over_claim;
    logic                                           short_free;
    logic                                           grant_fits;
    logic                                           walk_fit;
    logic [CLIENTS-1:0]                             done_next;
    logic                                           sweep_end;
    logic                                           all_done;
    logic                                           progress_next;
    logic                                           out_load;

    // claim fields, client-major; fields past the register's top read as zero
    assign claims_ext = {{(EXT_BITS - CFG_BITS){1'b0}}, claims_reg};

    always_comb begin
        int sh;
        for (int c = 0; c < ROWS; c++) begin
            for (int k = 0; k < KINDS; k++) begin
                sh = (c * KINDS + k) * COUNT_BITS;
                if (sh < CFG_BITS) begin
                    claim_arr[c][k] = claims_ext[sh +: COUNT_BITS];
                end else begin
                    claim_arr[c][k] = '0;
                end
            end
        end
    end

    // one row read port: walk index while walking, request client otherwise
    assign row_sel  = (state_reg == ST_WALK) ? walk_idx_reg : client_reg[CLI_BITS-1:0];
    assign held_row = held_reg[row_sel];

    // need is claim minus held, floored at zero
    always_comb begin
        for (int k = 0; k < KINDS; k++) begin
            if (claim_arr[row_sel][k] > held_row[k]) begin
                need_row[k] = claim_arr[row_sel][k] - held_row[k];
            end else begin
                need_row[k] = '0;
            end
        end
    end

    // amounts of unused kinds are dropped here
    always_comb begin
        for (int k = 0; k < KINDS; k++) begin
            amt_w[k] = WORK_BITS'(amount_reg[k]);
            amt_c[k] = amt_w[k][COUNT_BITS-1:0];
        end
    end

    assign client_ok = ({1'b0, client_reg} < CLIENTS_W);

    // request checks and can-finish test
    always_comb begin
        over_claim = 1'b0;
        short_free = 1'b0;
        grant_fits = 1'b1;
        for (int k = 0; k < KINDS; k++) begin
            if (amt_w[k] > WORK_BITS'(need_row[k])) over_claim = 1'b1;
            if (amt_w[k] > WORK_BITS'(free_reg[k])) short_free = 1'b1;
            if (need_row[k] > free_reg[k]) grant_fits = 1'b0;
        end
    end

    // one walk step: does the indexed unfinished client fit the work vector
    always_comb begin
        walk_fit = !done_reg[walk_idx_reg];
        for (int k = 0; k < KINDS; k++) begin
            if (WORK_BITS'(need_row[k]) > work_reg[k]) walk_fit = 1'b0;
        end
        done_next = done_reg;
        if (walk_fit) done_next[walk_idx_reg] = 1'b1;
    end

    assign sweep_end     = (walk_idx_reg == LAST_IDX);
    assign all_done      = &done_next;
    assign progress_next = progress_reg | walk_fit;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (action_reg == ACT_QUERY_SAFE) begin
                    state_next = ST_WINIT;
                end else if (action_reg == ACT_REQUEST && client_ok
                             && !over_claim && !short_free) begin
                    state_next = ST_WINIT;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_WINIT: begin
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (sweep_end) begin
                    if (all_done) begin
                        state_next = ST_RESP;
                    end else if (!progress_next) begin
                        state_next = (action_reg == ACT_REQUEST) ? ST_UNDO : ST_RESP;
                    end
                end
            end
            ST_UNDO: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        cfg_ready = 1'b1;
        out_load  = (state_reg == ST_RESP) && (!m_valid_reg || m_ready);
    end

    // control and allocation state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            claims_reg   <= CLAIM_RESET;
            free_reg     <= {KINDS{COUNT_BITS'(1)}};
            held_reg     <= '0;
            refusal_reg  <= '0;
            safe_reg     <= 1'b1;
            done_reg     <= '0;
            walk_idx_reg <= '0;
            progress_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) claims_reg <= cfg_data;

            case (state_reg)
                ST_EXEC: begin
                    case (action_reg)
                        ACT_REQUEST: begin
                            // tentative grant, rolled back if the walk fails
                            if (client_ok && !over_claim && !short_free) begin
                                for (int k = 0; k < KINDS; k++) begin
                                    free_reg[k] <= free_reg[k] - amt_c[k];
                                    held_reg[row_sel][k] <= held_row[k] + amt_c[k];
                                end
                            end
                        end
                        ACT_GRANT: begin
                            if (client_ok) begin
                                for (int k = 0; k < KINDS; k++) begin
                                    if (amt_w[k] <= WORK_BITS'(free_reg[k])
                                        && amt_w[k] <= WORK_BITS'(need_row[k])) begin
                                        free_reg[k] <= free_reg[k] - amt_c[k];
                                        held_reg[row_sel][k] <= held_row[k] + amt_c[k];
                                    end
                                end
                            end
                        end
                        ACT_RELEASE: begin
                            if (client_ok) begin
                                for (int k = 0; k < KINDS; k++) begin
                                    if ({1'b0, free_reg[k]} + {1'b0, held_row[k]}
                                        > {1'b0, COUNT_MAX}) begin
                                        free_reg[k] <= COUNT_MAX;
                                    end else begin
                                        free_reg[k] <= free_reg[k] + held_row[k];
                                    end
                                    held_reg[row_sel][k] <= '0;
                                end
                            end
                        end
                        ACT_LOAD_FREE: begin
                            for (int k = 0; k < KINDS; k++) begin
                                if (amt_w[k] > WORK_BITS'(COUNT_MAX)) begin
                                    free_reg[k] <= COUNT_MAX;
                                end else begin
                                    free_reg[k] <= amt_c[k];
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                ST_WINIT: begin
                    done_reg     <= '0;
                    walk_idx_reg <= '0;
                    progress_reg <= 1'b0;
                end
                ST_WALK: begin
                    done_reg <= done_next;
                    if (sweep_end) begin
                        walk_idx_reg <= '0;
                        progress_reg <= 1'b0;
                        if (all_done) begin
                            safe_reg <= 1'b1;
                        end else if (!progress_next) begin
                            safe_reg <= 1'b0;
                        end
                    end else begin
                        walk_idx_reg <= walk_idx_reg + 1'b1;
                        progress_reg <= progress_next;
                    end
                end
                ST_UNDO: begin
                    // roll the tentative grant back and count the refusal
                    for (int k = 0; k < KINDS; k++) begin
                        free_reg[k] <= free_reg[k] + amt_c[k];
                        held_reg[row_sel][k] <= held_row[k] - amt_c[k];
                    end
                    if (refusal_reg != '1) refusal_reg <= refusal_reg + 1'b1;
                end
                default: begin
                end
            endcase

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request latch, walk work vector, pending and delivered result
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg <= s_action;
            client_reg <= s_client;
            amount_reg <= {s_amount_3, s_amount_2, s_amount_1, s_amount_0};
        end

        case (state_reg)
            ST_EXEC: begin
                case (action_reg)
                    ACT_REQUEST: begin
                        ok_reg <= 1'b0;
                        if (client_ok && over_claim) begin
                            status_reg <= STAT_OVER_CLAIM;
                        end else if (client_ok && short_free) begin
                            status_reg <= STAT_SHORT_FREE;
                        end else begin
                            status_reg <= STAT_DONE;
                        end
                    end
                    ACT_GRANT, ACT_RELEASE: begin
                        ok_reg     <= client_ok;
                        status_reg <= STAT_DONE;
                    end
                    ACT_LOAD_FREE: begin
                        ok_reg     <= 1'b1;
                        status_reg <= STAT_DONE;
                    end
                    ACT_QUERY_FINISH: begin
                        ok_reg     <= client_ok && grant_fits;
                        status_reg <= STAT_DONE;
                    end
                    default: begin
                        ok_reg     <= 1'b0;
                        status_reg <= STAT_DONE;
                    end
                endcase
            end
            ST_WINIT: begin
                for (int k = 0; k < KINDS; k++) begin
                    work_reg[k] <= WORK_BITS'(free_reg[k]);
                end
            end
            ST_WALK: begin
                if (walk_fit) begin
                    for (int k = 0; k < KINDS; k++) begin
                        work_reg[k] <= work_reg[k] + WORK_BITS'(held_row[k]);
                    end
                end
                if (sweep_end && all_done) ok_reg <= 1'b1;
            end
            ST_UNDO: begin
                status_reg <= STAT_UNSAFE;
            end
            default: begin
            end
        endcase

        if (out_load) begin
            m_ok_reg      <= ok_reg;
            m_status_reg  <= status_reg;
            m_safe_reg    <= safe_reg;
            m_refusal_reg <= refusal_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_ok       = m_ok_reg;
    assign m_status   = m_status_reg;
    assign m_safe_now = m_safe_reg;
    assign m_refusals = m_refusal_reg;

`ifndef ASSERT_OFF
    // refusal counter only ever steps up by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(refusal_reg) |-> refusal_reg == $past(refusal_reg) + 1'b1)
        else $error("refusal counter jumped");

    // free counts stay put while the sequencer idles
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(state_reg) == ST_IDLE |-> $stable(free_reg))
        else $error("free counts changed in idle");

    // a rolled-back request is never reported as granted
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_UNSAFE |-> !m_ok)
        else $error("unsafe result marked ok");

    // the walk never runs past the last client row
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> walk_idx_reg <= LAST_IDX)
        else $error("walk index out of range");
`endif

endmodule

// File: dv/bsa_allocation_checker.sv
// checker that predicts every allocator result from the accepted requests and compares it
module bsa_allocation_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [bsa_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [bsa_pkg::ACTION_BITS-1:0]    s_action,
    input  logic [bsa_pkg::CLIENT_BITS-1:0]    s_client,
    input  logic [bsa_pkg::AMOUNT_BITS-1:0]    s_amount_0,
    input  logic [bsa_pkg::AMOUNT_BITS-1:0]    s_amount_1,
    input  logic [bsa_pkg::AMOUNT_BITS-1:0]    s_amount_2,
    input  logic [bsa_pkg::AMOUNT_BITS-1:0]    s_amount_3,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic                               m_ok,
    input  logic [bsa_pkg::STATUS_BITS-1:0]    m_status,
    input  logic                               m_safe_now,
    input  logic [bsa_pkg::REFUSAL_BITS-1:0]   m_refusals,
    output int                                 alloc_errors,
    output int                                 outstanding
);
    import bsa_pkg::*;

    localparam int NCLI      = CLIENTS_DEF;
    localparam int NKIND     = KINDS_DEF;
    localparam int CBITS     = COUNT_BITS_DEF;
    localparam int COUNT_TOP = (1 << CBITS) - 1;

    typedef struct packed {
        logic                    ok;
        logic [STATUS_BITS-1:0]  status;
        logic                    safe_now;
        logic [REFUSAL_BITS-1:0] refusals;
    } alloc_result_t;

    // shadow of the allocator state
    logic [63:0]             claim_word;
    logic [CBITS-1:0]        free_units [NKIND];
    logic [CBITS-1:0]        held_units [NCLI][NKIND];
    logic [REFUSAL_BITS-1:0] refusal_tally;
    logic                    safe_latch;

    alloc_result_t awaited_results [$];
    int fail_tally = 0;

    assign alloc_errors = fail_tally;

    function automatic int claim_at(int c, int k);
        int sh;
        sh = (c * NKIND + k) * CBITS;
        if (sh >= CFG_BITS) return 0;
        return int'(claim_word[sh +: CBITS]);
    endfunction

    // held above claim reads as zero need
    function automatic int need_at(int c, int k);
        int cl;
        int h;
        cl = claim_at(c, k);
        h = int'(held_units[c][k]);
        return (cl > h) ? cl - h : 0;
    endfunction

    function automatic logic walk_is_safe();
        int   work [NKIND];
        logic finished_row [NCLI];
        int   finished;
        logic found;
        logic fits;
        finished = 0;
        for (int k = 0; k < NKIND; k++) work[k] = int'(free_units[k]);
        for (int c = 0; c < NCLI; c++) finished_row[c] = 1'b0;
        for (int pass = 0; pass < NCLI; pass++) begin
            found = 1'b0;
            for (int c = 0; c < NCLI && !found; c++) begin
                if (!finished_row[c]) begin
                    fits = 1'b1;
                    for (int k = 0; k < NKIND; k++)
                        if (need_at(c, k) > work[k]) fits = 1'b0;
                    if (fits) begin
                        for (int k = 0; k < NKIND; k++) work[k] += int'(held_units[c][k]);
                        finished_row[c] = 1'b1;
                        finished++;
                        found = 1'b1;
                    end
                end
            end
            if (!found) break;
        end
        safe_latch = (finished == NCLI);
        return safe_latch;
    endfunction

    function automatic alloc_result_t banker_outcome(
        logic [ACTION_BITS-1:0] act,
        logic [CLIENT_BITS-1:0] who,
        logic [AMOUNT_BITS-1:0] a0,
        logic [AMOUNT_BITS-1:0] a1,
        logic [AMOUNT_BITS-1:0] a2,
        logic [AMOUNT_BITS-1:0] a3
    );
        int                     amt [NKIND];
        int                     c;
        int                     s;
        logic                   ok;
        logic [STATUS_BITS-1:0] status;
        alloc_result_t          res;
        amt[0] = int'(a0);
        amt[1] = int'(a1);
        amt[2] = int'(a2);
        amt[3] = int'(a3);
        c = int'(who);
        ok = 1'b0;
        status = STAT_DONE;
        case (act)
            ACT_REQUEST: begin
                if (c < NCLI) begin
                    for (int k = 0; k < NKIND; k++)
                        if (status == STAT_DONE && amt[k] > need_at(c, k))
                            status = STAT_OVER_CLAIM;
                    for (int k = 0; k < NKIND; k++)
                        if (status == STAT_DONE && amt[k] > int'(free_units[k]))
                            status = STAT_SHORT_FREE;
                    if (status == STAT_DONE) begin
                        for (int k = 0; k < NKIND; k++) begin
                            free_units[k] = CBITS'(int'(free_units[k]) - amt[k]);
                            held_units[c][k] = CBITS'(int'(held_units[c][k]) + amt[k]);
                        end
                        if (walk_is_safe()) begin
                            ok = 1'b1;
                        end else begin
                            // roll the tentative grant back
                            for (int k = 0; k < NKIND; k++) begin
                                free_units[k] = CBITS'(int'(free_units[k]) + amt[k]);
                                held_units[c][k] = CBITS'(int'(held_units[c][k]) - amt[k]);
                            end
                            if (refusal_tally != '1) refusal_tally = refusal_tally + 1'b1;
                            status = STAT_UNSAFE;
                        end
                    end
                end
            end
            ACT_GRANT: begin
                if (c < NCLI) begin
                    for (int k = 0; k < NKIND; k++) begin
                        if (amt[k] <= int'(free_units[k]) && amt[k] <= need_at(c, k)) begin
                            free_units[k] = CBITS'(int'(free_units[k]) - amt[k]);
                            held_units[c][k] = CBITS'(int'(held_units[c][k]) + amt[k]);
                        end
                    end
                    ok = 1'b1;
                end
            end
            ACT_RELEASE: begin
                if (c < NCLI) begin
                    for (int k = 0; k < NKIND; k++) begin
                        s = int'(free_units[k]) + int'(held_units[c][k]);
                        free_units[k] = CBITS'((s > COUNT_TOP) ? COUNT_TOP : s);
                        held_units[c][k] = '0;
                    end
                    ok = 1'b1;
                end
            end
            ACT_LOAD_FREE: begin
                for (int k = 0; k < NKIND; k++)
                    free_units[k] = CBITS'((amt[k] > COUNT_TOP) ? COUNT_TOP : amt[k]);
                ok = 1'b1;
            end
            ACT_QUERY_SAFE: begin
                ok = walk_is_safe();
            end
            ACT_QUERY_FINISH: begin
                if (c < NCLI) begin
                    ok = 1'b1;
                    for (int k = 0; k < NKIND; k++)
                        if (need_at(c, k) > int'(free_units[k])) ok = 1'b0;
                end
            end
            default: begin
            end
        endcase
        res.ok = ok;
        res.status = status;
        res.safe_now = safe_latch;
        res.refusals = refusal_tally;
        return res;
    endfunction

    always @(posedge aclk) begin : watch_channels
        alloc_result_t got;
        alloc_result_t want;
        if (!aresetn) begin
            claim_word = {1'b0, CLAIM_RESET};
            for (int k = 0; k < NKIND; k++) free_units[k] = CBITS'(1);
            for (int c = 0; c < NCLI; c++)
                for (int k = 0; k < NKIND; k++) held_units[c][k] = '0;
            refusal_tally = '0;
            safe_latch = 1'b1;
            awaited_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) claim_word = {1'b0, cfg_data};
            // results first: one accepted at this edge belongs to an older request
            if (m_valid && m_ready) begin
                got = {m_ok, m_status, m_safe_now, m_refusals};
                if (awaited_results.size() == 0) begin
                    fail_tally++;
                    if (fail_tally <= 10)
                        $display("%0t: result with nothing expected: ok=%0b status=%0d",
                                 $time, got.ok, got.status,
                                 " safe=%0b refusals=%0d", got.safe_now, got.refusals);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.ok !== want.ok || got.status !== want.status ||
                        got.safe_now !== want.safe_now || got.refusals !== want.refusals) begin
                        fail_tally++;
                        if (fail_tally <= 10)
                            $display("%0t: expected ok=%0b status=%0d safe=%0b refusals=%0d,",
                                     $time, want.ok, want.status, want.safe_now,
                                     want.refusals,
                                     " got ok=%0b status=%0d safe=%0b refusals=%0d",
                                     got.ok, got.status, got.safe_now, got.refusals);
                    end
                end
            end
            if (s_valid && s_ready)
                awaited_results.push_back(banker_outcome(s_action, s_client, s_amount_0,
                                                         s_amount_1, s_amount_2, s_amount_3));
        end
        outstanding <= awaited_results.size();
    end

endmodule

// File: dv/testbench.sv
// top of the allocator testbench: clock, reset, request and claim stimulus, verdict
module testbench;
    import bsa_pkg::*;

    // action codes the block treats as no-ops
    localparam logic [ACTION_BITS-1:0] ACT_NONE_A = 3'd6;
    localparam logic [ACTION_BITS-1:0] ACT_NONE_B = 3'd7;

    // cycles without any handshake before the run is declared hung
    localparam int STALL_LIMIT = 400;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 130;

    logic                    aclk       = 1'b0;
    logic                    aresetn    = 1'b0;
    logic                    cfg_valid  = 1'b0;
    logic                    cfg_ready;
    logic [CFG_BITS-1:0]     cfg_data   = '0;
    logic                    s_valid    = 1'b0;
    logic                    s_ready;
    logic [ACTION_BITS-1:0]  s_action   = ACT_QUERY_SAFE;
    logic [CLIENT_BITS-1:0]  s_client   = '0;
    logic [AMOUNT_BITS-1:0]  s_amount_0 = '0;
    logic [AMOUNT_BITS-1:0]  s_amount_1 = '0;
    logic [AMOUNT_BITS-1:0]  s_amount_2 = '0;
    logic [AMOUNT_BITS-1:0]  s_amount_3 = '0;
    logic                    m_valid;
    logic                    m_ready    = 1'b0;
    logic                    m_ok;
    logic [STATUS_BITS-1:0]  m_status;
    logic                    m_safe_now;
    logic [REFUSAL_BITS-1:0] m_refusals;

    int   alloc_errors;
    int   outstanding;
    int   idle_cycles = 0;
    int   rx_hold     = 0;
    logic tx_quiet    = 1'b0;
    logic rx_quiet    = 1'b0;

    // 20-unit clock period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    bankers_safe_allocator_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_client   (s_client),
        .s_amount_0 (s_amount_0),
        .s_amount_1 (s_amount_1),
        .s_amount_2 (s_amount_2),
        .s_amount_3 (s_amount_3),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_ok       (m_ok),
        .m_status   (m_status),
        .m_safe_now (m_safe_now),
        .m_refusals (m_refusals)
    );

    // predicts and compares beside the block; only the failure count and the outstanding count come back
    bsa_allocation_checker alloc_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_client     (s_client),
        .s_amount_0   (s_amount_0),
        .s_amount_1   (s_amount_1),
        .s_amount_2   (s_amount_2),
        .s_amount_3   (s_amount_3),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ok         (m_ok),
        .m_status     (m_status),
        .m_safe_now   (m_safe_now),
        .m_refusals   (m_refusals),
        .alloc_errors (alloc_errors),
        .outstanding  (outstanding)
    );

    // result side: after each accepted result draw a random stall,
    // counted down only while a result is actually waiting
    always @(posedge aclk) begin : result_sink
        int stall;
        if (!aresetn) begin
            m_ready <= 1'b1;
            rx_hold <= 0;
        end else if (m_valid && m_ready) begin
            stall = rx_quiet ? 0 : $urandom_range(0, 7);
            if (stall == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                rx_hold <= stall;
            end
        end else if (m_valid && !m_ready) begin
            // release on the last stall cycle, or at once if nothing is pending
            if (rx_hold <= 1) begin
                m_ready <= 1'b1;
                rx_hold <= 0;
            end else begin
                rx_hold <= rx_hold - 1;
            end
        end
    end

    // hang detector: any handshake or reset clears the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("bankers_safe_allocator_core: mismatch");
                $finish;
            end
        end
    end

    // one request: optional gap with valid low, then hold valid until accepted;
    // entered and left at a rising edge so back-to-back requests keep valid high
    task automatic send_request(input logic [ACTION_BITS-1:0] act,
                                input logic [CLIENT_BITS-1:0] who,
                                input logic [AMOUNT_BITS-1:0] a0,
                                input logic [AMOUNT_BITS-1:0] a1,
                                input logic [AMOUNT_BITS-1:0] a2,
                                input logic [AMOUNT_BITS-1:0] a3);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= act;
        s_client   <= who;
        s_amount_0 <= a0;
        s_amount_1 <= a1;
        s_amount_2 <= a2;
        s_amount_3 <= a3;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // claim register write, only issued while the allocator is idle
    task automatic write_claims(input logic [CFG_BITS-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // drop valid, wait for every predicted result, then let the block idle before returning
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    // claim fields drawn up to a ceiling; small ceilings make refusals common
    function automatic logic [CFG_BITS-1:0] draw_claims(int ceiling);
        logic [63:0] word;
        for (int i = 0; i < 16; i++) word[i*4 +: 4] = 4'($urandom_range(0, ceiling));
        return word[CFG_BITS-1:0];
    endfunction

    // mostly small amounts that fit typical needs, now and then the full range
    function automatic logic [AMOUNT_BITS-1:0] draw_amount(int ceiling);
        if ($urandom_range(0, 9) == 0) return AMOUNT_BITS'($urandom_range(0, 15));
        return AMOUNT_BITS'($urandom_range(0, ceiling));
    endfunction

    task automatic send_random_request(input int free_ceiling);
        int                     pick;
        logic [ACTION_BITS-1:0] act;
        logic [CLIENT_BITS-1:0] who;
        int                     lim;
        pick = $urandom_range(0, 99);
        who  = CLIENT_BITS'($urandom_range(0, 3));
        if (pick < 40)       act = ACT_REQUEST;
        else if (pick < 50)  act = ACT_GRANT;
        else if (pick < 63)  act = ACT_RELEASE;
        else if (pick < 73)  act = ACT_LOAD_FREE;
        else if (pick < 85)  act = ACT_QUERY_SAFE;
        else if (pick < 97)  act = ACT_QUERY_FINISH;
        else if (pick < 99)  act = ACT_NONE_A;
        else                 act = ACT_NONE_B;
        // requests and grants stay near real needs, free loads near the claim scale
        if (act == ACT_LOAD_FREE)
            lim = free_ceiling;
        else if (act == ACT_REQUEST || act == ACT_GRANT)
            lim = 2;
        else
            lim = 15;
        send_request(act, who, draw_amount(lim), draw_amount(lim),
                     draw_amount(lim), draw_amount(lim));
    endtask

    initial begin : stimulus
        int claim_ceiling;
        // hold the synchronous reset, then release it
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset claims: clients 0 and 2 want kinds 0 and 2, clients 1 and 3 kinds 1 and 3
        send_request(ACT_QUERY_SAFE,   2'd0, 4'd0, 4'd0, 4'd0, 4'd0);
        send_request(ACT_QUERY_FINISH, 2'd0, 4'd0, 4'd0, 4'd0, 4'd0);
        send_request(ACT_REQUEST,      2'd0, 4'd1, 4'd0, 4'd0, 4'd0);  // granted
        send_request(ACT_REQUEST,      2'd2, 4'd0, 4'd0, 4'd1, 4'd0);  // leaves 0 and 2 stuck
        send_request(ACT_REQUEST,      2'd1, 4'd1, 4'd0, 4'd0, 4'd0);  // beyond claim
        send_request(ACT_REQUEST,      2'd2, 4'd1, 4'd0, 4'd0, 4'd0);  // kind 0 exhausted
        send_request(ACT_QUERY_FINISH, 2'd2, 4'd0, 4'd0, 4'd0, 4'd0);
        // unchecked grant skips kind 0, takes kind 2, and the state turns unsafe
        send_request(ACT_GRANT,        2'd2, 4'd1, 4'd0, 4'd1, 4'd0);
        send_request(ACT_QUERY_SAFE,   2'd3, 4'd0, 4'd0, 4'd0, 4'd0);
        send_request(ACT_RELEASE,      2'd2, 4'd0, 4'd0, 4'd0, 4'd0);
        send_request(ACT_QUERY_SAFE,   2'd1, 4'd0, 4'd0, 4'd0, 4'd0);
        send_request(ACT_LOAD_FREE,    2'd3, 4'd15, 4'd15, 4'd15, 4'd15);
        send_request(ACT_RELEASE,      2'd0, 4'd0, 4'd0, 4'd0, 4'd0);  // free saturates
        send_request(ACT_NONE_A,       2'd3, 4'd15, 4'd15, 4'd15, 4'd15);
        send_request(ACT_NONE_B,       2'd1, 4'd0, 4'd0, 4'd0, 4'd0);
        send_request(ACT_LOAD_FREE,    2'd0, 4'd0, 4'd0, 4'd0, 4'd0);
        send_request(ACT_QUERY_SAFE,   2'd0, 4'd0, 4'd0, 4'd0, 4'd0);
        settle();

        // every claim field at its maximum, but the top field reads 7 since its last bit lies past the register
        write_claims({CFG_BITS{1'b1}});
        send_request(ACT_LOAD_FREE,    2'd0, 4'd15, 4'd15, 4'd15, 4'd15);
        send_request(ACT_REQUEST,      2'd3, 4'd15, 4'd15, 4'd15, 4'd15);
        send_request(ACT_REQUEST,      2'd1, 4'd1, 4'd0, 4'd0, 4'd0);
        send_request(ACT_GRANT,        2'd3, 4'd15, 4'd15, 4'd15, 4'd15);
        send_request(ACT_RELEASE,      2'd3, 4'd0, 4'd0, 4'd0, 4'd0);
        settle();

        // no claims at all: only zero requests pass
        write_claims('0);
        send_request(ACT_REQUEST,      2'd2, 4'd0, 4'd0, 4'd0, 4'd0);
        send_request(ACT_REQUEST,      2'd2, 4'd0, 4'd0, 4'd0, 4'd1);
        settle();

        // random phases, each under its own claim setting and idling mode
        for (int ph = 0; ph < PHASES; ph++) begin
            claim_ceiling = (ph % 3 == 2) ? 15 : $urandom_range(1, 4);
            write_claims(draw_claims(claim_ceiling));
            tx_quiet = (ph % 4 == 1);
            rx_quiet = (ph % 4 == 2) || (ph == PHASES - 1);
            repeat (PHASE_ITEMS) send_random_request(claim_ceiling + 1);
            settle();
        end

        if (alloc_errors == 0 && outstanding == 0)
            $display("bankers_safe_allocator_core: match");
        else
            $display("bankers_safe_allocator_core: mismatch");
        $finish;
    end

endmodule
